### design/bfa_pkg.sv
// shared constants, types and codes for the bitmap fit allocator
// no dependencies; imported by every module of the block
package bfa_pkg;

  localparam int BLOCKS   = 128;
  localparam int AW       = $clog2(BLOCKS);
  localparam int CW       = $clog2(BLOCKS + 1);
  localparam int CMD_W    = 2;
  localparam int LEN_W    = 8;
  localparam int START_W  = 7;
  localparam int STATUS_W = 2;
  localparam int LW       = (CW > LEN_W) ? CW : LEN_W;
  localparam int SUM_W    = ((CW > START_W) ? ((CW > LEN_W) ? CW : LEN_W)
                                            : ((START_W > LEN_W) ? START_W : LEN_W)) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIRST = 2'd0,
    CMD_BEST  = 2'd1,
    CMD_WORST = 2'd2,
    CMD_FREE  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_INVALID = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_PICK,
    S_MARK,
    S_RESP
  } state_e;

  // one bit of the map as it comes back from the memory
  typedef struct packed {
    logic          vld;
    logic          occ;
    logic [AW-1:0] idx;
  } scan_beat_t;

  // hole chosen so far by the scan
  typedef struct packed {
    logic          found;
    logic [AW-1:0] start;
  } hole_res_t;

endpackage

### design/bfa_map_ram.sv
// occupancy map storage: one bit per block, one write and one read port
// registered read data; depends on bfa_pkg
module bfa_map_ram
  import bfa_pkg::*;
(
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [BLOCKS];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/bfa_hole_scan.sv
// hole tracker: follows the map bit by bit and keeps the hole picked by the policy
// depends on bfa_pkg
module bfa_hole_scan
  import bfa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  scan_beat_t       beat_i,
  input  cmd_e             policy_i,
  input  logic [LEN_W-1:0] req_len_i,
  output hole_res_t        res_o
);

  logic          in_hole_q, in_hole_d;
  logic          found_q, found_d;
  logic [CW-1:0] hole_len_q, hole_len_d;
  logic [AW-1:0] hole_start_q, hole_start_d;
  logic [CW-1:0] best_len_q, best_len_d;
  logic [AW-1:0] best_start_q, best_start_d;

  logic          is_free, is_last, closes, fits, better;
  logic [CW-1:0] len_inc, close_len;
  logic [AW-1:0] close_start;

  always_comb begin
    is_free     = !beat_i.occ;
    is_last     = (beat_i.idx == AW'(BLOCKS - 1));
    len_inc     = in_hole_q ? hole_len_q + CW'(1) : CW'(1);
    // a hole ends at an occupied bit or at the end of the map
    closes      = beat_i.vld && ((beat_i.occ && in_hole_q) || (is_free && is_last));
    close_len   = beat_i.occ ? hole_len_q : len_inc;
    close_start = in_hole_q ? hole_start_q : beat_i.idx;
    fits        = LW'(close_len) >= LW'(req_len_i);
    case (policy_i)
      CMD_FIRST: better = !found_q;
      CMD_BEST:  better = !found_q || (close_len < best_len_q);
      CMD_WORST: better = !found_q || (close_len > best_len_q);
      default:   better = 1'b0;
    endcase

    in_hole_d    = in_hole_q;
    found_d      = found_q;
    hole_len_d   = hole_len_q;
    hole_start_d = hole_start_q;
    best_len_d   = best_len_q;
    best_start_d = best_start_q;
    if (start_i) begin
      in_hole_d = 1'b0;
      found_d   = 1'b0;
    end else if (beat_i.vld) begin
      in_hole_d    = is_free;
      hole_len_d   = is_free ? len_inc : '0;
      hole_start_d = close_start;
      if (closes && fits && better) begin
        found_d      = 1'b1;
        best_len_d   = close_len;
        best_start_d = close_start;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_hole_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      in_hole_q <= in_hole_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_len_q   <= hole_len_d;
    hole_start_q <= hole_start_d;
    best_len_q   <= best_len_d;
    best_start_q <= best_start_d;
  end

  assign res_o.found = found_q;
  assign res_o.start = best_start_q;

endmodule

### design/bitmap_fit_allocator.sv
// bitmap fit allocator: first, best and worst fit allocation and free over a 128-block occupancy map
// an allocation scans the whole map, picks a hole, marks the run if one is found and
// responds; a free clears its run and responds; a rejected request goes straight to the
// response step. one request in flight: the next one is taken only after the result has
// entered the output register. the map port reads one bit per cycle while scanning and
// writes one bit per cycle while marking. after reset a clearing pass zeroes the map
module bitmap_fit_allocator
  import bfa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [LEN_W-1:0]    run_length_i,
  input  logic [START_W-1:0]  free_start_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [START_W-1:0]  run_start_o
);

  // control state
  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;             // clear and scan address counter
  logic          beat_vld_q;
  logic          out_valid_q, out_valid_d;

  // request and working payload
  cmd_e             cmd_q, cmd_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] rem_q, rem_d;          // blocks still to mark
  logic [AW-1:0]    mark_addr_q, mark_addr_d;
  logic             mark_val_q, mark_val_d;
  status_e          res_status_q, res_status_d;
  logic [START_W-1:0] res_start_q, res_start_d;
  logic [AW-1:0]    beat_idx_q;
  status_e          status_q, status_d;
  logic [START_W-1:0] run_start_q, run_start_d;

  // memory port and scan wiring
  logic          ram_we, ram_wdata, ram_re, ram_rdata;
  logic [AW-1:0] ram_waddr;
  scan_beat_t    beat;
  hole_res_t     hole;

  logic                in_acc;
  logic                len_zero;
  logic                free_oob;
  logic                slot_free;
  cmd_e                in_cmd;

  assign in_cmd    = cmd_e'(cmd_i);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign len_zero  = (run_length_i == '0);
  // a free must stay inside the map
  assign free_oob  = (SUM_W'(free_start_i) + SUM_W'(run_length_i)) > SUM_W'(BLOCKS);
  // the output register can take a new result when empty or being drained
  assign slot_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (cnt_q == CW'(BLOCKS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (len_zero) begin
            state_d = S_RESP;
          end else if (in_cmd == CMD_FREE) begin
            state_d = free_oob ? S_RESP : S_MARK;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_q == CW'(BLOCKS - 1)) state_d = S_TAIL;
      end
      S_TAIL: state_d = S_PICK;   // last bit reaches the tracker
      S_PICK: state_d = hole.found ? S_MARK : S_RESP;
      S_MARK: begin
        if (rem_q == LEN_W'(1)) state_d = S_RESP;
      end
      S_RESP: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // state outputs: handshake and memory port
  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = mark_addr_q;
    ram_wdata  = mark_val_q;
    ram_re     = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
        ram_wdata = 1'b0;
      end
      S_IDLE: in_stall_o = 1'b0;
      S_SCAN: ram_re = 1'b1;
      S_MARK: ram_we = 1'b1;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    cnt_d        = cnt_q;
    cmd_d        = cmd_q;
    len_d        = len_q;
    rem_d        = rem_q;
    mark_addr_d  = mark_addr_q;
    mark_val_d   = mark_val_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    run_start_d  = run_start_q;
    case (state_q)
      S_CLEAR, S_SCAN: cnt_d = cnt_q + CW'(1);
      S_IDLE: begin
        if (in_acc) begin
          cmd_d        = in_cmd;
          len_d        = run_length_i;
          cnt_d        = '0;
          res_status_d = STAT_INVALID;
          res_start_d  = '0;
          if (!len_zero && in_cmd == CMD_FREE && !free_oob) begin
            res_status_d = STAT_DONE;
            res_start_d  = free_start_i;
            mark_addr_d  = AW'(free_start_i);
            mark_val_d   = 1'b0;
            rem_d        = run_length_i;
          end
        end
      end
      S_PICK: begin
        if (hole.found) begin
          res_status_d = STAT_DONE;
          res_start_d  = START_W'(hole.start);
          mark_addr_d  = hole.start;
          mark_val_d   = 1'b1;
          rem_d        = len_q;
        end else begin
          res_status_d = STAT_NOSPACE;
          res_start_d  = '0;
        end
      end
      S_MARK: begin
        mark_addr_d = mark_addr_q + AW'(1);
        rem_d       = rem_q - LEN_W'(1);
      end
      S_RESP: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          run_start_d = res_start_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      beat_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      beat_vld_q  <= (state_q == S_SCAN);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    len_q        <= len_d;
    rem_q        <= rem_d;
    mark_addr_q  <= mark_addr_d;
    mark_val_q   <= mark_val_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    beat_idx_q   <= cnt_q[AW-1:0];
    status_q     <= status_d;
    run_start_q  <= run_start_d;
  end

  // scan and mark never overlap, so no forwarding is needed on the map
  bfa_map_ram u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign beat.vld = beat_vld_q;
  assign beat.occ = ram_rdata;
  assign beat.idx = beat_idx_q;

  bfa_hole_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == S_IDLE),
    .beat_i    (beat),
    .policy_i  (cmd_q),
    .req_len_i (len_q),
    .res_o     (hole)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign run_start_o = run_start_q;

  // a result only appears after the response step
  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result raised outside the response step");

  // the map is never read and written in the same cycle
  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("map read and write in the same cycle");

  // failed requests report start zero
  a_err_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != STAT_DONE) |-> (run_start_q == '0))
    else $error("non-zero start on a failed request");

  // marking only follows a found hole or an accepted free
  a_mark_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_MARK) |-> $past(state_q == S_IDLE) || $past(hole.found))
    else $error("marking without a hole");

endmodule

### tb/bitmap_fit_allocator_tb.sv
// testbench for the bitmap fit allocator: directed and random requests checked against
// a block map tracker kept in step with every accepted request
// depends on bfa_pkg and bitmap_fit_allocator
module bitmap_fit_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfa_pkg::*;

  // one expected result
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  start;
  } grant_t;

  // mirror of the occupancy map and the grants still owed by the block
  class block_map_tracker;
    bit          occ_map [BLOCKS];
    grant_t      pending_grants [$];
    int unsigned mismatches = 0;

    task flag_mismatch(string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatches++;
    endtask

    // apply an accepted request to the map and queue the grant it yields
    function void predict_request(cmd_e op, logic [LEN_W-1:0] len, logic [START_W-1:0] fs);
      grant_t      g;
      int unsigned want, i, hs, hl, pick, pick_len;
      bit          found;
      want  = len;
      g.status = STAT_DONE;
      g.start  = '0;
      found = 1'b0;
      pick  = 0;
      pick_len = 0;
      if (want == 0) begin
        g.status = STAT_INVALID;
      end else if (op == CMD_FREE) begin
        if (int'(fs) + want > BLOCKS) begin
          g.status = STAT_INVALID;
        end else begin
          for (int b = int'(fs); b < int'(fs) + int'(want); b++) occ_map[b] = 1'b0;
          g.start = fs;
        end
      end else begin
        // walk whole holes, keeping the one the policy prefers, lowest start on ties
        i = 0;
        while (want <= BLOCKS && i < BLOCKS) begin
          if (occ_map[i]) begin
            i++;
            continue;
          end
          hs = i;
          while (i < BLOCKS && !occ_map[i]) i++;
          hl = i - hs;
          if (hl < want) continue;
          if (!found || (op == CMD_BEST && hl < pick_len) ||
              (op == CMD_WORST && hl > pick_len)) begin
            found    = 1'b1;
            pick     = hs;
            pick_len = hl;
          end
          if (op == CMD_FIRST) break;
        end
        if (found) begin
          for (int b = int'(pick); b < int'(pick + want); b++) occ_map[b] = 1'b1;
          g.start = pick[START_W-1:0];
        end else begin
          g.status = STAT_NOSPACE;
        end
      end
      pending_grants.push_back(g);
    endfunction

    task check_grant(logic [STATUS_W-1:0] status, logic [START_W-1:0] start);
      grant_t g;
      if (pending_grants.size() == 0) begin
        flag_mismatch($sformatf("result status %0d start %0d with no request pending",
                                status, start));
      end else begin
        g = pending_grants.pop_front();
        if (status !== g.status)
          flag_mismatch($sformatf("status %0d, expected %0d", status, g.status));
        if (start !== g.start)
          flag_mismatch($sformatf("run_start %0d, expected %0d", start, g.start));
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    cmd_i        = CMD_FIRST;
  logic [LEN_W-1:0]    run_length_i = '0;
  logic [START_W-1:0]  free_start_i = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [START_W-1:0]  run_start_o;

  int unsigned send_idle_pct  = 28;
  int unsigned recv_stall_pct = 84;

  block_map_tracker tracker = new();

  bitmap_fit_allocator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .run_length_i (run_length_i),
    .free_start_i (free_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .run_start_o  (run_start_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side: check on accept, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_grant(status_o, run_start_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // present one request, optionally after an idle gap, and hold it until accepted
  task automatic send_req(cmd_e op, logic [LEN_W-1:0] len, logic [START_W-1:0] fs);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= op;
    run_length_i <= len;
    free_start_i <= fs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.predict_request(op, len, fs);
  endtask

  // allocation: mostly short runs, some long, a few zero or oversize lengths
  task automatic send_random_alloc();
    int unsigned r, len;
    cmd_e        op;
    op = cmd_e'($urandom_range(CMD_WORST));
    r  = $urandom_range(99);
    if (r < 3)       len = 0;
    else if (r < 6)  len = $urandom_range(255, BLOCKS + 1);
    else if (r < 14) len = $urandom_range(BLOCKS, 17);
    else             len = $urandom_range(16, 1);
    send_req(op, len[LEN_W-1:0], START_W'($urandom_range(BLOCKS - 1)));
  endtask

  // free: mostly runs starting on an occupied block, plus whole-map and broken frees
  task automatic send_random_free();
    int unsigned r, fs, len;
    int          taken [$];
    for (int b = 0; b < BLOCKS; b++) if (tracker.occ_map[b]) taken.push_back(b);
    r = $urandom_range(99);
    if (r < 3) begin
      fs  = $urandom_range(BLOCKS - 1);
      len = 0;
    end else if (r < 8) begin
      fs  = $urandom_range(BLOCKS - 1);
      len = $urandom_range(255, 1);
    end else if (r < 11) begin
      fs  = 0;
      len = BLOCKS;
    end else if (r < 78 && taken.size() > 0) begin
      fs  = taken[$urandom_range(taken.size() - 1)];
      len = $urandom_range((BLOCKS - fs < 24) ? BLOCKS - fs : 24, 1);
    end else begin
      fs  = $urandom_range(BLOCKS - 1);
      len = $urandom_range(BLOCKS - fs, 1);
    end
    send_req(CMD_FREE, len[LEN_W-1:0], fs[START_W-1:0]);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: full map, carved holes for each policy, ties, bounds, zero and oversize
    send_req(CMD_FIRST, 8'd128, 7'd0);
    send_req(CMD_BEST,  8'd1,   7'd0);
    send_req(CMD_FREE,  8'd5,   7'd10);
    send_req(CMD_FREE,  8'd3,   7'd40);
    send_req(CMD_FREE,  8'd20,  7'd80);
    send_req(CMD_FREE,  8'd3,   7'd120);
    send_req(CMD_BEST,  8'd3,   7'd0);
    send_req(CMD_BEST,  8'd3,   7'd0);
    send_req(CMD_WORST, 8'd2,   7'd0);
    send_req(CMD_FIRST, 8'd4,   7'd0);
    send_req(CMD_WORST, 8'd19,  7'd0);
    send_req(CMD_FREE,  8'd2,   7'd127);
    send_req(CMD_FREE,  8'd1,   7'd127);
    send_req(CMD_FREE,  8'd128, 7'd0);
    send_req(CMD_FREE,  8'd5,   7'd0);
    send_req(CMD_FIRST, 8'd0,   7'd0);
    send_req(CMD_BEST,  8'd0,   7'd127);
    send_req(CMD_WORST, 8'd0,   7'd0);
    send_req(CMD_FREE,  8'd0,   7'd5);
    send_req(CMD_WORST, 8'd129, 7'd0);
    send_req(CMD_FIRST, 8'd255, 7'd0);
    send_req(CMD_WORST, 8'd128, 7'd0);
    send_req(CMD_FREE,  8'd255, 7'd0);
    send_req(CMD_FREE,  8'd128, 7'd0);

    // random: slow receiver then slow sender, then both at full rate
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct  = 84;
        recv_stall_pct = 28;
      end else if (phase == 2) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      for (int n = 0; n < 609; n++) begin
        if ($urandom_range(99) < 55) send_random_alloc();
        else                         send_random_free();
      end
    end
    in_valid_i <= 1'b0;

    while (tracker.pending_grants.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_grants.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

endmodule

### bitmap_fit_allocator.f
design/bfa_pkg.sv
design/bfa_map_ram.sv
design/bfa_hole_scan.sv
design/bitmap_fit_allocator.sv
tb/bitmap_fit_allocator_tb.sv
